// ===== rtl/gait_phase_tracker_macros.svh =====
// gait_phase_tracker_macros.svh: assertion macros for the gait phase tracker
// expects clk and arst_n in the scope that uses them
`ifndef GAIT_PHASE_TRACKER_MACROS_SVH
`define GAIT_PHASE_TRACKER_MACROS_SVH

// same-cycle implication
`define GPT_ASSERT_IMP(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) else $error(msg);

// next-cycle implication
`define GPT_ASSERT_NXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) else $error(msg);

`endif

// ===== rtl/gpt_pkg.sv =====
// gpt_pkg: constants and types shared by the gait phase tracker
// no dependencies
package gpt_pkg;

	localparam int LEG_COUNT_DEF  = 4;
	localparam int PHASE_BINS_DEF = 8;
	localparam int PORT_LEGS      = 4;

	localparam logic [16:0] Q16_ONE      = 17'd65536;
	localparam logic [16:0] SPAN_FLOOR   = 17'd20;
	localparam logic [19:0] ERR_MAX      = 20'hFFFFF;
	localparam logic [19:0] PERIOD_FLOOR = 20'd256;

	localparam logic [16:0] LEVEL_ALPHA_RST    = 17'd655;
	localparam logic [16:0] PLANT_FRACTION_RST = 17'd16384;
	localparam logic [16:0] LIFT_FRACTION_RST  = 17'd32768;
	localparam logic [16:0] PERIOD_ALPHA_RST   = 17'd3277;
	localparam logic [16:0] ERROR_ALPHA_RST    = 17'd3277;
	localparam logic [11:0] MIN_PERIOD_RST     = 12'd10;
	localparam logic [11:0] MAX_PERIOD_RST     = 12'd180;

	localparam logic [2:0] REG_LEVEL_ALPHA    = 3'd0;
	localparam logic [2:0] REG_PLANT_FRACTION = 3'd1;
	localparam logic [2:0] REG_LIFT_FRACTION  = 3'd2;
	localparam logic [2:0] REG_PERIOD_ALPHA   = 3'd3;
	localparam logic [2:0] REG_ERROR_ALPHA    = 3'd4;
	localparam logic [2:0] REG_MIN_PERIOD     = 3'd5;
	localparam logic [2:0] REG_MAX_PERIOD     = 3'd6;

	localparam int DIV_NW = 40;
	localparam int DIV_DW = 20;
	localparam int DIV_CW = $clog2(DIV_NW + 1);

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_NW-1:0] quo;
		logic [DIV_DW-1:0] rem;
	} div_rsp_t;

endpackage

// ===== rtl/gpt_div.sv =====
// gpt_div: restoring divider, one quotient bit per cycle
// depends on gpt_pkg
module gpt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gpt_pkg::div_req_t req,
	output gpt_pkg::div_rsp_t rsp
);

	logic [gpt_pkg::DIV_CW-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [gpt_pkg::DIV_DW-1:0] den_q;
	logic [gpt_pkg::DIV_DW-1:0] rem_q;
	logic [gpt_pkg::DIV_NW-1:0] quo_q;
	logic [gpt_pkg::DIV_DW:0]   trial;
	logic                       ge;

	assign trial = {rem_q, quo_q[gpt_pkg::DIV_NW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= gpt_pkg::DIV_CW'(gpt_pkg::DIV_NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == gpt_pkg::DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			quo_q <= req.num;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? gpt_pkg::DIV_DW'(trial - {1'b0, den_q})
			            : trial[gpt_pkg::DIV_DW-1:0];
			quo_q <= {quo_q[gpt_pkg::DIV_NW-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== rtl/gait_phase_tracker.sv =====
// gait_phase_tracker: per-leg touchdown, period and phase tracking
// depends on gpt_pkg, gpt_div and gait_phase_tracker_macros.svh
// legs run one after another; a repeat touchdown adds period and error updates and a
// confidence division, and two divisions give the phase bin once a period exists
// no new item is taken until the result is loaded into the output register
// reset clears all leg state and loads the register defaults at once
module gait_phase_tracker #(
	parameter int LEG_COUNT  = gpt_pkg::LEG_COUNT_DEF,
	parameter int PHASE_BINS = gpt_pkg::PHASE_BINS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tick, foot_y_0, foot_y_1, foot_y_2, foot_y_3
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// planted_mask, touchdown_mask, phase_bin_0..3, confidence_0..3
	output logic [87:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	localparam int NLEG = (LEG_COUNT < gpt_pkg::PORT_LEGS) ? LEG_COUNT : gpt_pkg::PORT_LEGS;
	localparam int LW   = (NLEG > 1) ? $clog2(NLEG) : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LEVEL, ST_LEVEL_UPD, ST_PLANT, ST_LIFT, ST_DECIDE,
		ST_PER, ST_PER_UPD, ST_ERR, ST_ERR_UPD, ST_PRED, ST_CONF,
		ST_PHASE, ST_MOD, ST_BIN, ST_OUT
	} state_t;

	state_t state_q;

	logic [16:0] level_alpha_q, plant_fraction_q, lift_fraction_q;
	logic [16:0] period_alpha_q, error_alpha_q;
	logic [11:0] min_period_q, max_period_q;
	logic [16:0] cfg_sat;

	logic        seeded_q  [NLEG];
	logic        planted_q [NLEG];
	logic [15:0] low_q     [NLEG];
	logic [15:0] high_q    [NLEG];
	logic        seen_q    [NLEG];
	logic [31:0] last_q    [NLEG];
	logic        pv_q      [NLEG];
	logic [31:0] pred_q    [NLEG];
	logic [19:0] per_q     [NLEG];
	logic [19:0] err_q     [NLEG];
	logic [16:0] conf_q    [NLEG];

	logic [31:0] tick_q;
	logic [15:0] foot_q [gpt_pkg::PORT_LEGS];
	logic [1:0]  leg_q;
	logic [2:0]  bin_q  [gpt_pkg::PORT_LEGS];
	logic [3:0]  tmask_q;
	logic signed [17:0] plant_thr_q;
	logic [19:0] obs_q;
	logic [19:0] errv_q;
	logic signed [39:0] prod_q;
	logic        m_tvalid_q;
	logic [87:0] m_tdata_q;

	gpt_pkg::div_req_t div_req_q;
	gpt_pkg::div_rsp_t div_rsp;

	logic [LW-1:0]      li;
	logic [15:0]        y;
	logic signed [17:0] y18;
	logic signed [16:0] span_raw;
	logic [16:0]        span;
	logic signed [39:0] rnd;
	logic signed [17:0] thr;
	logic [16:0]        mul_a;
	logic signed [21:0] mul_b;
	logic [31:0]        dlast;
	logic [31:0]        dpred;
	logic [11:0]        lo_p, hi_p, iv;
	logic [19:0]        errv;
	logic [19:0]        per_floor;
	logic               last_leg;
	logic [3:0]         pmask;
	logic [87:0]        out_word;

	assign cfg_sat = (cfg_data > gpt_pkg::Q16_ONE) ? gpt_pkg::Q16_ONE : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_alpha_q    <= gpt_pkg::LEVEL_ALPHA_RST;
			plant_fraction_q <= gpt_pkg::PLANT_FRACTION_RST;
			lift_fraction_q  <= gpt_pkg::LIFT_FRACTION_RST;
			period_alpha_q   <= gpt_pkg::PERIOD_ALPHA_RST;
			error_alpha_q    <= gpt_pkg::ERROR_ALPHA_RST;
			min_period_q     <= gpt_pkg::MIN_PERIOD_RST;
			max_period_q     <= gpt_pkg::MAX_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gpt_pkg::REG_LEVEL_ALPHA:    level_alpha_q    <= cfg_sat;
				gpt_pkg::REG_PLANT_FRACTION: plant_fraction_q <= cfg_sat;
				gpt_pkg::REG_LIFT_FRACTION:  lift_fraction_q  <= cfg_sat;
				gpt_pkg::REG_PERIOD_ALPHA:   period_alpha_q   <= cfg_sat;
				gpt_pkg::REG_ERROR_ALPHA:    error_alpha_q    <= cfg_sat;
				gpt_pkg::REG_MIN_PERIOD:     min_period_q     <= cfg_data[11:0];
				gpt_pkg::REG_MAX_PERIOD:     max_period_q     <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		li        = leg_q[LW-1:0];
		y         = foot_q[leg_q];
		y18       = {{2{y[15]}}, y};
		span_raw  = $signed({high_q[li][15], high_q[li]}) - $signed({low_q[li][15], low_q[li]});
		span      = (span_raw < $signed(gpt_pkg::SPAN_FLOOR)) ? gpt_pkg::SPAN_FLOOR
		                                                      : span_raw;
		rnd       = (prod_q + 40'sd32768) >>> 16;
		thr       = $signed({{2{low_q[li][15]}}, low_q[li]}) + $signed({1'b0, prod_q[32:16]});
		dlast     = tick_q - last_q[li];
		dpred     = tick_q - pred_q[li];
		if (dpred[31])
			dpred = 32'd0 - dpred;
		errv      = (|dpred[31:12]) ? gpt_pkg::ERR_MAX : {dpred[11:0], 8'd0};
		lo_p      = (min_period_q == 12'd0) ? 12'd1 : min_period_q;
		hi_p      = (max_period_q < 12'd2) ? 12'd2 : max_period_q;
		iv        = (dlast < {20'd0, lo_p}) ? lo_p : dlast[11:0];
		if ((dlast >= {20'd0, lo_p}) && (|dlast[31:12] || dlast[11:0] > hi_p))
			iv = hi_p;
		if (iv > hi_p)
			iv = hi_p;
		per_floor = (per_q[li] < gpt_pkg::PERIOD_FLOOR) ? gpt_pkg::PERIOD_FLOOR : per_q[li];
		last_leg  = (leg_q == 2'(NLEG - 1));
		mul_a     = level_alpha_q;
		mul_b     = 22'(y18 - $signed(planted_q[li] ? {{2{low_q[li][15]}}, low_q[li]}
		                                            : {{2{high_q[li][15]}}, high_q[li]}));
		case (state_q)
			ST_PLANT: begin
				mul_a = plant_fraction_q;
				mul_b = $signed({5'd0, span});
			end
			ST_LIFT: begin
				mul_a = lift_fraction_q;
				mul_b = $signed({5'd0, span});
			end
			ST_PER: begin
				mul_a = period_alpha_q;
				mul_b = $signed({2'd0, obs_q}) - $signed({2'd0, per_q[li]});
			end
			ST_ERR: begin
				mul_a = error_alpha_q;
				mul_b = $signed({2'd0, errv_q}) - $signed({2'd0, err_q[li]});
			end
			default: ;
		endcase
	end

	always_comb begin
		pmask = '0;
		out_word = '0;
		for (int i = 0; i < gpt_pkg::PORT_LEGS; i++) begin
			if (i < NLEG) begin
				pmask[i] = planted_q[LW'(i)];
				out_word[20 + 17*i +: 17] = conf_q[LW'(i)];
			end
			out_word[8 + 3*i +: 3] = bin_q[i];
		end
		out_word[3:0] = pmask;
		out_word[7:4] = tmask_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			leg_q       <= '0;
			tmask_q     <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			div_req_q   <= '0;
			tick_q      <= '0;
			plant_thr_q <= '0;
			obs_q       <= '0;
			errv_q      <= '0;
			prod_q      <= '0;
			for (int i = 0; i < NLEG; i++) begin
				seeded_q[i]  <= 1'b0;
				planted_q[i] <= 1'b0;
				low_q[i]     <= '0;
				high_q[i]    <= '0;
				seen_q[i]    <= 1'b0;
				last_q[i]    <= '0;
				pv_q[i]      <= 1'b0;
				pred_q[i]    <= '0;
				per_q[i]     <= '0;
				err_q[i]     <= '0;
				conf_q[i]    <= '0;
			end
			for (int i = 0; i < gpt_pkg::PORT_LEGS; i++) begin
				bin_q[i]  <= '0;
				foot_q[i] <= '0;
			end
		end else begin
			div_req_q.start <= (state_q == ST_PRED)
			                || ((state_q == ST_PHASE) && seen_q[li] && (per_q[li] != 20'd0))
			                || ((state_q == ST_MOD) && div_rsp.done);
			if (m_tvalid_q && m_tready && (state_q != ST_OUT))
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						tick_q    <= s_tdata[31:0];
						foot_q[0] <= s_tdata[47:32];
						foot_q[1] <= s_tdata[63:48];
						foot_q[2] <= s_tdata[79:64];
						foot_q[3] <= s_tdata[95:80];
						leg_q     <= '0;
						tmask_q   <= '0;
						for (int i = 0; i < gpt_pkg::PORT_LEGS; i++)
							bin_q[i] <= '0;
						state_q   <= ST_LEVEL;
					end
				end
				ST_LEVEL: begin
					if (!seeded_q[li]) begin
						low_q[li]    <= y;
						high_q[li]   <= y;
						seeded_q[li] <= 1'b1;
						state_q      <= ST_PLANT;
					end else begin
						prod_q  <= $signed({1'b0, mul_a}) * mul_b;
						state_q <= ST_LEVEL_UPD;
					end
				end
				ST_LEVEL_UPD: begin
					if (planted_q[li])
						low_q[li] <= low_q[li] + rnd[15:0];
					else
						high_q[li] <= high_q[li] + rnd[15:0];
					state_q <= ST_PLANT;
				end
				ST_PLANT: begin
					prod_q  <= $signed({1'b0, mul_a}) * mul_b;
					state_q <= ST_LIFT;
				end
				ST_LIFT: begin
					plant_thr_q <= thr;
					prod_q      <= $signed({1'b0, mul_a}) * mul_b;
					state_q     <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= ST_PHASE;
					if (!planted_q[li] && (y18 <= plant_thr_q)) begin
						planted_q[li]  <= 1'b1;
						tmask_q[leg_q] <= 1'b1;
						if (!seen_q[li]) begin
							seen_q[li] <= 1'b1;
							last_q[li] <= tick_q;
							pv_q[li]   <= 1'b0;
						end else begin
							obs_q   <= {iv, 8'd0};
							errv_q  <= pv_q[li] ? errv : {1'b0, iv, 7'd0};
							state_q <= ST_PER;
						end
					end else if (planted_q[li] && (y18 >= thr)) begin
						planted_q[li] <= 1'b0;
					end
				end
				ST_PER: begin
					if (per_q[li] == 20'd0) begin
						per_q[li] <= obs_q;
						state_q   <= ST_ERR;
					end else begin
						prod_q  <= $signed({1'b0, mul_a}) * mul_b;
						state_q <= ST_PER_UPD;
					end
				end
				ST_PER_UPD: begin
					per_q[li] <= per_q[li] + rnd[19:0];
					state_q   <= ST_ERR;
				end
				ST_ERR: begin
					if (err_q[li] == 20'd0) begin
						err_q[li] <= errv_q;
						state_q   <= ST_PRED;
					end else begin
						prod_q  <= $signed({1'b0, mul_a}) * mul_b;
						state_q <= ST_ERR_UPD;
					end
				end
				ST_ERR_UPD: begin
					err_q[li] <= err_q[li] + rnd[19:0];
					state_q   <= ST_PRED;
				end
				ST_PRED: begin
					last_q[li]      <= tick_q;
					pred_q[li]      <= tick_q + {20'd0, per_q[li][19:8]};
					pv_q[li]        <= 1'b1;
					div_req_q.num   <= {4'd0, err_q[li], 16'd0};
					div_req_q.den   <= per_floor;
					state_q         <= ST_CONF;
				end
				ST_CONF: begin
					if (div_rsp.done) begin
						conf_q[li] <= (|div_rsp.quo[39:16]) ? 17'd0
						                                   : gpt_pkg::Q16_ONE - div_rsp.quo[16:0];
						state_q    <= ST_PHASE;
					end
				end
				ST_PHASE: begin
					if (seen_q[li] && (per_q[li] != 20'd0)) begin
						div_req_q.num   <= {dlast, 8'd0};
						div_req_q.den   <= per_floor;
						state_q         <= ST_MOD;
					end else if (last_leg) begin
						state_q <= ST_OUT;
					end else begin
						leg_q   <= leg_q + 1'b1;
						state_q <= ST_LEVEL;
					end
				end
				ST_MOD: begin
					if (div_rsp.done) begin
						div_req_q.num   <= 40'({20'd0, div_rsp.rem} * 40'(PHASE_BINS));
						state_q         <= ST_BIN;
					end
				end
				ST_BIN: begin
					if (div_rsp.done) begin
						bin_q[leg_q] <= div_rsp.quo[2:0];
						if (last_leg) begin
							state_q <= ST_OUT;
						end else begin
							leg_q   <= leg_q + 1'b1;
							state_q <= ST_LEVEL;
						end
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= out_word;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	gpt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`include "gait_phase_tracker_macros.svh"

	`GPT_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
	`GPT_ASSERT_IMP(a_div_start_idle, div_req_q.start, !div_rsp.busy, "divider restarted busy")
	`GPT_ASSERT_IMP(a_td_planted, m_tvalid, (m_tdata[7:4] & ~m_tdata[3:0]) == 4'd0, "touchdown unplanted")
	`GPT_ASSERT_NXT(a_out_load, (state_q == ST_OUT) && (!m_tvalid || m_tready), m_tvalid, "item lost")

endmodule
